>>> sv/sic_pkg.sv
`default_nettype none

package sic_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CNT_W = 5;
   localparam int unsigned UPC_W = 5;
   localparam int unsigned ITER_W = $clog2(DATA_W);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W - 1);
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_PEEK = 3'd2,
      OP_ADD  = 3'd3,
      OP_SUB  = 3'd4,
      OP_MUL  = 3'd5,
      OP_DIV  = 3'd6,
      OP_DEC  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      A_NOP,
      A_LATCH,
      A_PUSH,
      A_RD_TOP,
      A_LD_B,
      A_LD_B_RD_SEC,
      A_LD_A,
      A_POP,
      A_PEEK,
      A_DEC,
      A_ADD,
      A_SUB,
      A_MUL_INIT,
      A_MUL_STEP,
      A_DIV_INIT,
      A_DIV_STEP,
      A_DIV_FIX,
      A_WB,
      A_EMIT,
      A_SET_UNDER,
      A_SET_OVER,
      A_SET_DIVZ
   } act_type;

   typedef enum logic [3:0] {
      C_NEXT,
      C_JUMP,
      C_DISPATCH,
      C_DISPATCH_ALU,
      C_NO_ACCEPT,
      C_EMPTY,
      C_LT2,
      C_FULL,
      C_BZERO,
      C_ITER,
      C_FREE
   } cond_type;

   typedef struct packed {
      act_type          act;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic   accept;
      logic   empty;
      logic   lt2;
      logic   full;
      logic   bzero;
      logic   iter_more;
      logic   out_busy;
      op_type op;
   } flags_type;

   localparam logic [UPC_W-1:0] U_FETCH     = 5'd0;
   localparam logic [UPC_W-1:0] U_DECODE    = 5'd1;
   localparam logic [UPC_W-1:0] U_PUSH      = 5'd2;
   localparam logic [UPC_W-1:0] U_POP       = 5'd4;
   localparam logic [UPC_W-1:0] U_PEEK      = 5'd7;
   localparam logic [UPC_W-1:0] U_DEC       = 5'd10;
   localparam logic [UPC_W-1:0] U_BIN       = 5'd13;
   localparam logic [UPC_W-1:0] U_ADD       = 5'd16;
   localparam logic [UPC_W-1:0] U_SUB       = 5'd17;
   localparam logic [UPC_W-1:0] U_MUL       = 5'd18;
   localparam logic [UPC_W-1:0] U_MUL_LOOP  = 5'd19;
   localparam logic [UPC_W-1:0] U_DIV       = 5'd21;
   localparam logic [UPC_W-1:0] U_DIV_LOOP  = 5'd22;
   localparam logic [UPC_W-1:0] U_WB        = 5'd24;
   localparam logic [UPC_W-1:0] U_EMIT      = 5'd25;
   localparam logic [UPC_W-1:0] U_ERR_UNDER = 5'd27;
   localparam logic [UPC_W-1:0] U_ERR_OVER  = 5'd28;
   localparam logic [UPC_W-1:0] U_ERR_DIVZ  = 5'd29;

   function automatic logic [UPC_W-1:0] op_map(op_type op);
      logic [UPC_W-1:0] addr;
      case (op)
         OP_PUSH: addr = U_PUSH;
         OP_POP:  addr = U_POP;
         OP_PEEK: addr = U_PEEK;
         OP_DEC:  addr = U_DEC;
         default: addr = U_BIN;
      endcase
      return addr;
   endfunction

   function automatic logic [UPC_W-1:0] alu_map(op_type op);
      logic [UPC_W-1:0] addr;
      case (op)
         OP_ADD:  addr = U_ADD;
         OP_SUB:  addr = U_SUB;
         OP_MUL:  addr = U_MUL;
         OP_DIV:  addr = U_DIV;
         default: addr = U_FETCH;
      endcase
      return addr;
   endfunction

   function automatic ctrl_word_type ucode_rom(logic [UPC_W-1:0] addr);
      ctrl_word_type cw;
      case (addr)
         5'd0:    cw = '{A_LATCH,       C_NO_ACCEPT,    U_FETCH};
         5'd1:    cw = '{A_NOP,         C_DISPATCH,     U_FETCH};
         5'd2:    cw = '{A_NOP,         C_FULL,         U_ERR_OVER};
         5'd3:    cw = '{A_PUSH,        C_JUMP,         U_EMIT};
         5'd4:    cw = '{A_RD_TOP,      C_EMPTY,        U_ERR_UNDER};
         5'd5:    cw = '{A_LD_B,        C_NEXT,         U_FETCH};
         5'd6:    cw = '{A_POP,         C_JUMP,         U_EMIT};
         5'd7:    cw = '{A_RD_TOP,      C_EMPTY,        U_ERR_UNDER};
         5'd8:    cw = '{A_LD_B,        C_NEXT,         U_FETCH};
         5'd9:    cw = '{A_PEEK,        C_JUMP,         U_EMIT};
         5'd10:   cw = '{A_RD_TOP,      C_EMPTY,        U_ERR_UNDER};
         5'd11:   cw = '{A_LD_B,        C_NEXT,         U_FETCH};
         5'd12:   cw = '{A_DEC,         C_JUMP,         U_EMIT};
         5'd13:   cw = '{A_RD_TOP,      C_LT2,          U_ERR_UNDER};
         5'd14:   cw = '{A_LD_B_RD_SEC, C_NEXT,         U_FETCH};
         5'd15:   cw = '{A_LD_A,        C_DISPATCH_ALU, U_FETCH};
         5'd16:   cw = '{A_ADD,         C_JUMP,         U_WB};
         5'd17:   cw = '{A_SUB,         C_JUMP,         U_WB};
         5'd18:   cw = '{A_MUL_INIT,    C_NEXT,         U_FETCH};
         5'd19:   cw = '{A_MUL_STEP,    C_ITER,         U_MUL_LOOP};
         5'd20:   cw = '{A_NOP,         C_JUMP,         U_WB};
         5'd21:   cw = '{A_DIV_INIT,    C_BZERO,        U_ERR_DIVZ};
         5'd22:   cw = '{A_DIV_STEP,    C_ITER,         U_DIV_LOOP};
         5'd23:   cw = '{A_DIV_FIX,     C_JUMP,         U_WB};
         5'd24:   cw = '{A_WB,          C_NEXT,         U_FETCH};
         5'd25:   cw = '{A_EMIT,        C_FREE,         U_FETCH};
         5'd26:   cw = '{A_NOP,         C_JUMP,         U_EMIT};
         5'd27:   cw = '{A_SET_UNDER,   C_JUMP,         U_EMIT};
         5'd28:   cw = '{A_SET_OVER,    C_JUMP,         U_EMIT};
         5'd29:   cw = '{A_SET_DIVZ,    C_JUMP,         U_EMIT};
         default: cw = '{A_NOP,         C_JUMP,         U_FETCH};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

>>> sv/stack_integer_calculator.sv
`default_nettype none

// Stack calculator on signed 32-bit integers, run by a small microprogram.
// The request channel carries one beat per operation (op and value); the
// response channel returns one beat per request with result, status and
// the stack depth after the operation. Both channels use valid and stall.
// A new request is taken only when the sequencer is back at its fetch step.
// Multiply runs 32 shift-add steps and divide 32 restoring-divide steps,
// both counted by one shared iteration counter; errors finish early.
// The stack lives in a RAM with one write and one registered read port,
// so the two operands of a binary operation are read in turn.
// A stalled response beat holds; the sequencer waits at its emit step until
// the response register is free, and the next request can be taken while
// that beat still waits. Reset empties the stack, sets the capacity to 16
// and drops any pending response; the RAM is not cleared. The user must
// write capacity through the csr port only while the block is idle; the
// block itself does not enforce this.

module stack_integer_calculator #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_op,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_result,
   output logic [1:0]              rsp_status,
   output logic [4:0]              rsp_depth,
   input  wire logic               csr_we,
   input  wire logic [4:0]         csr_wdata
);

   import sic_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned DEPTH_CAP = (DEPTH < 31) ? DEPTH : 31;
   localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(DEPTH_CAP);

   flags_type         flags;
   act_type           act;
   logic              at_fetch;
   logic              accept;
   logic              out_busy;

   op_type            op_ff;
   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic              sign_ff, sign_in;
   logic [ITER_W-1:0] it_ff, it_in;
   status_type        st_ff, st_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  lim;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_result_ff;
   status_type        rsp_status_ff;
   logic [CNT_W-1:0]  rsp_depth_ff;

   logic              we;
   logic [AW-1:0]     waddr;
   logic [DATA_W-1:0] wdata;
   logic [AW-1:0]     raddr;
   logic [DATA_W-1:0] rdata;

   logic [DATA_W:0]   rem_sh;
   logic              div_ge;

   assign req_stall = !at_fetch || reset;
   assign accept    = req_valid && at_fetch && !reset;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign lim       = (cap_ff > DEPTH_LIM) ? DEPTH_LIM : cap_ff;

   assign flags.accept    = accept;
   assign flags.empty     = (count_ff == '0);
   assign flags.lt2       = (count_ff < CNT_W'(2));
   assign flags.full      = (count_ff >= lim);
   assign flags.bzero     = (b_ff == '0);
   assign flags.iter_more = (it_ff != ITER_LAST);
   assign flags.out_busy  = out_busy;
   assign flags.op        = op_ff;

   sic_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .flags    (flags),
      .at_fetch (at_fetch),
      .act      (act)
   );

   sic_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign raddr = (act == A_LD_B_RD_SEC) ? AW'(count_ff - CNT_W'(2))
                                         : AW'(count_ff - CNT_W'(1));
   assign we    = (act == A_PUSH) || (act == A_WB);
   assign waddr = (act == A_PUSH) ? AW'(count_ff) : AW'(count_ff - CNT_W'(2));
   assign wdata = (act == A_PUSH) ? val_ff : acc_ff;

   assign rem_sh = {rem_ff, a_ff[DATA_W-1]};
   assign div_ge = (rem_sh >= {1'b0, b_ff});

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      sign_in  = sign_ff;
      it_in    = it_ff;
      st_in    = st_ff;
      count_in = count_ff;
      case (act)
         A_LATCH: begin
            st_in  = ST_OK;
            acc_in = '0;
         end
         A_PUSH: begin
            acc_in   = val_ff;
            count_in = count_ff + CNT_W'(1);
         end
         A_LD_B, A_LD_B_RD_SEC: b_in = rdata;
         A_LD_A: a_in = rdata;
         A_POP: begin
            acc_in   = b_ff;
            count_in = count_ff - CNT_W'(1);
         end
         A_PEEK: acc_in = b_ff;
         A_DEC:  acc_in = b_ff - DATA_W'(1);
         A_ADD:  acc_in = a_ff + b_ff;
         A_SUB:  acc_in = a_ff - b_ff;
         A_MUL_INIT: begin
            acc_in = '0;
            it_in  = '0;
         end
         A_MUL_STEP: begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in  = {a_ff[DATA_W-2:0], 1'b0};
            b_in  = {1'b0, b_ff[DATA_W-1:1]};
            it_in = it_ff + ITER_W'(1);
         end
         A_DIV_INIT: begin
            a_in    = a_ff[DATA_W-1] ? -a_ff : a_ff;
            b_in    = b_ff[DATA_W-1] ? -b_ff : b_ff;
            sign_in = a_ff[DATA_W-1] ^ b_ff[DATA_W-1];
            rem_in  = '0;
            it_in   = '0;
         end
         A_DIV_STEP: begin
            rem_in = div_ge ? DATA_W'(rem_sh - {1'b0, b_ff}) : rem_sh[DATA_W-1:0];
            a_in   = {a_ff[DATA_W-2:0], div_ge};
            it_in  = it_ff + ITER_W'(1);
         end
         A_DIV_FIX: acc_in = sign_ff ? -a_ff : a_ff;
         A_WB: count_in = count_ff - CNT_W'(1);
         A_SET_UNDER: begin
            st_in  = ST_UNDER;
            acc_in = '0;
         end
         A_SET_OVER: begin
            st_in  = ST_OVER;
            acc_in = '0;
         end
         A_SET_DIVZ: begin
            st_in  = ST_DIVZ;
            acc_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_op);
         val_ff <= req_value;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      sign_ff <= sign_in;
      it_ff   <= it_in;
      st_ff   <= st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (act == A_EMIT && !out_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (act == A_EMIT && !out_busy) begin
         rsp_result_ff <= acc_ff;
         rsp_status_ff <= st_ff;
         rsp_depth_ff  <= count_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = $signed(rsp_result_ff);
   assign rsp_status = rsp_status_ff;
   assign rsp_depth  = rsp_depth_ff;

endmodule

`default_nettype wire

>>> sv/sic_ram.sv
`default_nettype none

module sic_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> sv/sic_sequencer.sv
`default_nettype none

module sic_sequencer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sic_pkg::flags_type flags,
   output logic                    at_fetch,
   output sic_pkg::act_type        act
);

   import sic_pkg::*;

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   ctrl_word_type    cw;
   logic             hit;

   assign cw       = ucode_rom(upc_ff);
   assign act      = cw.act;
   assign at_fetch = (upc_ff == U_FETCH);

   always_comb begin
      case (cw.cond)
         C_JUMP:      hit = 1'b1;
         C_NO_ACCEPT: hit = !flags.accept;
         C_EMPTY:     hit = flags.empty;
         C_LT2:       hit = flags.lt2;
         C_FULL:      hit = flags.full;
         C_BZERO:     hit = flags.bzero;
         C_ITER:      hit = flags.iter_more;
         C_FREE:      hit = !flags.out_busy;
         default:     hit = 1'b0;
      endcase
   end

   always_comb begin
      case (cw.cond)
         C_DISPATCH:     upc_in = op_map(flags.op);
         C_DISPATCH_ALU: upc_in = alu_map(flags.op);
         default:        upc_in = hit ? cw.target : upc_ff + UPC_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire
